@@ rtl/mexp_pkg.sv @@
package mexp_pkg;

  localparam int MOD_W    = 31;
  localparam int IN_W     = 63;
  localparam int DIV_W    = 2 * MOD_W + 1;
  localparam int EXP_BITS_DEF = 63;
  localparam int PC_W     = 4;
  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 32;

  localparam logic [MOD_W-1:0] RESET_MODULUS = 31'd1000000007;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_NOP,
    OP_RED,
    OP_MUL_ACC,
    OP_MUL_PW,
    OP_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    CND_NEXT,
    CND_ALWAYS,
    CND_E_ZERO,
    CND_M_ZERO,
    CND_BIT_CLR,
    CND_E_LAST
  } cond_t;

  localparam logic [PC_W-1:0] ST_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] ST_CHK_E    = 4'd1;
  localparam logic [PC_W-1:0] ST_CHK_M    = 4'd2;
  localparam logic [PC_W-1:0] ST_RED_BASE = 4'd3;
  localparam logic [PC_W-1:0] ST_TEST     = 4'd4;
  localparam logic [PC_W-1:0] ST_MUL_ACC  = 4'd5;
  localparam logic [PC_W-1:0] ST_RED_ACC  = 4'd6;
  localparam logic [PC_W-1:0] ST_MUL_PW   = 4'd7;
  localparam logic [PC_W-1:0] ST_RED_PW   = 4'd8;
  localparam logic [PC_W-1:0] ST_EMIT     = 4'd9;
  localparam logic [PC_W-1:0] ST_ZERO     = 4'd10;

  typedef struct packed {
    op_t             op;
    logic            dst_acc;
    logic            shift_e;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    op_t  op;
    logic dst_acc;
    logic shift_e;
    logic advance;
    logic red_start;
  } ctrl_t;

  typedef struct packed {
    logic in_xfer;
    logic out_free;
    logic red_done;
    logic e_zero;
    logic e_last;
    logic bit0;
    logic m_zero;
  } status_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NOP, dst_acc: 1'b0, shift_e: 1'b0, cond: CND_ALWAYS, target: ST_IDLE};
    case (pc)
      ST_IDLE:     w = '{OP_IDLE,    1'b0, 1'b0, CND_NEXT,    ST_IDLE};
      ST_CHK_E:    w = '{OP_NOP,     1'b0, 1'b0, CND_E_ZERO,  ST_EMIT};
      ST_CHK_M:    w = '{OP_NOP,     1'b0, 1'b0, CND_M_ZERO,  ST_ZERO};
      ST_RED_BASE: w = '{OP_RED,     1'b0, 1'b0, CND_NEXT,    ST_IDLE};
      ST_TEST:     w = '{OP_NOP,     1'b0, 1'b0, CND_BIT_CLR, ST_MUL_PW};
      ST_MUL_ACC:  w = '{OP_MUL_ACC, 1'b0, 1'b0, CND_NEXT,    ST_IDLE};
      ST_RED_ACC:  w = '{OP_RED,     1'b1, 1'b0, CND_NEXT,    ST_IDLE};
      ST_MUL_PW:   w = '{OP_MUL_PW,  1'b0, 1'b1, CND_E_LAST,  ST_EMIT};
      ST_RED_PW:   w = '{OP_RED,     1'b0, 1'b0, CND_ALWAYS,  ST_TEST};
      ST_EMIT:     w = '{OP_EMIT,    1'b0, 1'b0, CND_ALWAYS,  ST_IDLE};
      ST_ZERO:     w = '{OP_ZERO,    1'b0, 1'b0, CND_ALWAYS,  ST_EMIT};
      default:     w = '{OP_NOP,     1'b0, 1'b0, CND_ALWAYS,  ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/mexp_reducer.sv @@
module mexp_reducer
  import mexp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [MOD_W-1:0] modulus,
  output logic             busy,
  output logic             done,
  output logic [MOD_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MOD_W:0]   trial;

  always_comb begin
    trial    = {rem_r, dvd_r[DIV_W-1]};
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      cnt_nxt  = CNT_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, modulus}) begin
        rem_nxt = MOD_W'(trial - {1'b0, modulus});
      end else begin
        rem_nxt = trial[MOD_W-1:0];
      end
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign remainder = rem_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("Reducer finished without having run.");

  a_remainder_below_mod: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && (modulus != '0) |-> rem_r < modulus)
    else $error("Reducer remainder is not below the modulus.");

  a_no_restart_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("Reducer started while busy.");

endmodule

@@ rtl/mexp_sequencer.sv @@
module mexp_sequencer
  import mexp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            started_r, started_nxt;
  uword_t          uw;
  logic            step_done;
  logic            take_jump;

  always_comb begin
    uw = ucode(pc_r);
    case (uw.op)
      OP_IDLE: step_done = status.in_xfer;
      OP_RED:  step_done = status.red_done;
      OP_EMIT: step_done = status.out_free;
      default: step_done = 1'b1;
    endcase
    case (uw.cond)
      CND_ALWAYS:  take_jump = 1'b1;
      CND_E_ZERO:  take_jump = status.e_zero;
      CND_M_ZERO:  take_jump = status.m_zero;
      CND_BIT_CLR: take_jump = !status.bit0;
      CND_E_LAST:  take_jump = status.e_last;
      default:     take_jump = 1'b0;
    endcase
    pc_nxt      = pc_r;
    started_nxt = started_r;
    if (uw.op == OP_RED && !started_r) begin
      started_nxt = 1'b1;
    end
    if (step_done) begin
      pc_nxt      = take_jump ? uw.target : pc_r + 1'b1;
      started_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r      <= ST_IDLE;
      started_r <= 1'b0;
    end else begin
      pc_r      <= pc_nxt;
      started_r <= started_nxt;
    end
  end

  always_comb begin
    ctrl.op        = uw.op;
    ctrl.dst_acc   = uw.dst_acc;
    ctrl.shift_e   = uw.shift_e;
    ctrl.advance   = step_done;
    ctrl.red_start = (uw.op == OP_RED) && !started_r;
  end

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// Modular exponentiation, right-to-left binary square-and-multiply.
// Input channel in_*: one transfer carries a base and an exponent.
// Result channel out_*: one transfer per input carries base^exponent mod m.
// The modulus is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, which the block itself does not enforce.
// It resets to 1000000007. A microcoded sequencer steps a datapath holding
// a 31 by 31 bit multiplier and a restoring remainder unit that retires one
// dividend bit per cycle. A zero exponent goes straight to a result of one,
// and a zero modulus with a nonzero exponent gives zero without a multiply.
// One item is worked on at a time; the next input transfer is taken only
// once the result has been placed and the sequencer is back in idle.
// The result sits in an output register; while the receiver stalls the
// next item may already be taken and computed, and the sequencer waits
// only when it must place a new result. Reset empties the output register
// and returns the sequencer to idle.
module modular_exponentiation_top
  import mexp_pkg::*;
#(
  parameter int EXP_BITS = EXP_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [MOD_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // base_value [62:0], exponent [125:63], zero fill [127:126]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // power_result [30:0], zero fill [31]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [MOD_W-1:0]       modulus_r;
  logic [DIV_W-1:0]       x_r;
  logic [EXP_BITS-1:0]    e_r;
  logic [MOD_W-1:0]       acc_r;
  logic [MOD_W-1:0]       pw_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [2*MOD_W-1:0]     prod;
  logic                   red_busy;
  logic                   red_done;
  logic [MOD_W-1:0]       red_rem;
  status_t                status;
  ctrl_t                  ctrl;

  mexp_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  mexp_reducer u_red (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctrl.red_start),
    .dividend  (x_r),
    .modulus   (modulus_r),
    .busy      (red_busy),
    .done      (red_done),
    .remainder (red_rem)
  );

  assign in_tready = (ctrl.op == OP_IDLE);

  always_comb begin
    status.in_xfer  = in_tvalid && in_tready;
    status.out_free = !out_valid_r || out_tready;
    status.red_done = red_done;
    status.e_zero   = (e_r == '0);
    status.e_last   = ((e_r >> 1) == '0);
    status.bit0     = e_r[0];
    status.m_zero   = (modulus_r == '0);
  end

  always_comb begin
    if (ctrl.op == OP_MUL_ACC) begin
      prod = (2*MOD_W)'(acc_r) * (2*MOD_W)'(pw_r);
    end else begin
      prod = (2*MOD_W)'(pw_r) * (2*MOD_W)'(pw_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= RESET_MODULUS;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (status.in_xfer) begin
          x_r   <= in_tdata[IN_W-1:0];
          e_r   <= in_tdata[IN_W +: EXP_BITS];
          acc_r <= MOD_W'(1);
        end
      end
      OP_MUL_ACC, OP_MUL_PW: begin
        x_r <= {1'b0, prod};
        if (ctrl.shift_e) begin
          e_r <= e_r >> 1;
        end
      end
      OP_RED: begin
        if (red_done) begin
          if (ctrl.dst_acc) begin
            acc_r <= red_rem;
          end else begin
            pw_r <= red_rem;
          end
        end
      end
      OP_ZERO: acc_r <= '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.op == OP_EMIT && status.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (ctrl.op == OP_EMIT && status.out_free) begin
      out_data_r <= {{(OUT_TDATA_W-MOD_W){1'b0}}, acc_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_idle_reducer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !red_busy)
    else $error("Reducer busy while the block accepts an item.");

  a_done_only_in_red: assert property (@(posedge clk) disable iff (!rst_n)
    red_done |-> ctrl.op == OP_RED)
    else $error("Reduction finished outside a reduction step.");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctrl.op == OP_EMIT))
    else $error("Result placed without an emit step.");

  a_emit_never_overwrites: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_EMIT && out_valid_r && !out_tready |=> $stable(out_data_r))
    else $error("Pending result overwritten.");

endmodule

@@ bench/modular_exponentiation_top_test.sv @@
`timescale 1ns / 100ps

module modular_exponentiation_top_test;
  import mexp_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int STALL_CYCLES = 6000;
  localparam int TAIL_CYCLES = 9000;
  localparam logic [IN_W-1:0] FIELD_MAX = {IN_W{1'b1}};
  localparam logic [MOD_W-1:0] MOD_MAX = {MOD_W{1'b1}};

  typedef struct packed {
    logic [IN_W-1:0] exponent;
    logic [IN_W-1:0] base_value;
  } power_req_t;

  typedef struct packed {
    power_req_t      req;
    logic [MOD_W-1:0] power_result;
  } power_due_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [MOD_W-1:0]       cfg_wdata = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  power_req_t       pending_requests[$];
  power_due_t       awaited_powers[$];
  power_req_t       offered_req;
  logic [MOD_W-1:0] modulus_now = RESET_MODULUS;
  bit               steady = 1'b0;
  bit               hold_done = 1'b0;
  int               hold_left = 0;
  int               cycle_count = 0;
  int               mismatch_count = 0;
  int               results_checked = 0;
  int               settings_used = 1;
  int               full_width_exps = 0;

  modular_exponentiation_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [MOD_W-1:0] expected_power(input logic [IN_W-1:0] base_value,
                                                       input logic [IN_W-1:0] exponent,
                                                       input logic [MOD_W-1:0] m);
    logic [63:0] acc;
    logic [63:0] pw;
    logic [63:0] mm;
    if (exponent == '0) return MOD_W'(1);
    if (m == '0) return '0;
    mm = 64'(m);
    acc = 64'd1;
    pw = 64'(base_value) % mm;
    for (int i = 0; i < IN_W; i++) begin
      if (exponent[i]) acc = (acc * pw) % mm;
      pw = (pw * pw) % mm;
    end
    return acc[MOD_W-1:0];
  endfunction

  function automatic logic [IN_W-1:0] random_field();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[IN_W-1:0];
  endfunction

  task automatic queue_request(input logic [IN_W-1:0] base_value,
                               input logic [IN_W-1:0] exponent);
    power_req_t r;
    r.base_value = base_value;
    r.exponent = exponent;
    pending_requests.push_back(r);
  endtask

  task automatic add_random_requests(input int count);
    logic [63:0]     b;
    logic [IN_W-1:0] e;
    int              width;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(3))
        0: b = 64'(random_field());
        1: b = 64'($urandom_range(20));
        2: b = 64'(modulus_now) * 64'($urandom_range(1000)) + 64'($urandom_range(3));
        default: b = 64'($urandom & MOD_MAX);
      endcase
      // Long exponents are slow, so only about one request in sixteen uses all bits.
      if ($urandom_range(15) == 0) begin
        e = random_field();
        full_width_exps++;
      end else begin
        width = $urandom_range(12);
        e = random_field() & ((63'd1 << width) - 63'd1);
      end
      queue_request(b[IN_W-1:0], e);
    end
  endtask

  task automatic write_modulus(input logic [MOD_W-1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    modulus_now = m;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    while (pending_requests.size() != 0 || in_tvalid || awaited_powers.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_power(input logic [MOD_W-1:0] got);
    power_due_t due;
    if (awaited_powers.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("unexpected result %0d with nothing outstanding", got);
    end else begin
      due = awaited_powers.pop_front();
      results_checked++;
      if (got !== due.power_result) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch: base %0d exponent %0d expected %0d got %0d",
                   due.req.base_value, due.req.exponent, due.power_result, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        awaited_powers.push_back('{offered_req, expected_power(offered_req.base_value,
                                                               offered_req.exponent,
                                                               modulus_now)});
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          offered_req = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, offered_req.exponent, offered_req.base_value};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_power(out_tdata[MOD_W-1:0]);
      // A single long stall lets the block fill up and refuse further input transfers.
      if (!hold_done && results_checked == 40) begin
        hold_left = STALL_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || $urandom_range(99) >= 30;
      end
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("modular_exponentiation_top_test: done, errors");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    queue_request('0, '0);
    queue_request('0, 63'd5);
    queue_request(FIELD_MAX, '0);
    queue_request(FIELD_MAX, FIELD_MAX);
    queue_request(63'd2, 63'd1);
    queue_request(63'd2, 63'd1 << 62);
    queue_request(63'd3, FIELD_MAX);
    queue_request(63'd1000000007, 63'd3);
    queue_request(63'd1000000006, 63'd2);
    queue_request(63'd2000000019, 63'd10);
    queue_request(63'd123456789, 63'd1 << 31);
    queue_request(63'd7, 63'h2AAA_AAAA_AAAA_AAAA);
    queue_request(FIELD_MAX, 63'd1);
    queue_request(63'd12345, 63'h5555_5555_5555_5555);
    add_random_requests(90);
    drain();

    write_modulus(MOD_MAX);
    steady = 1'b1;
    add_random_requests(60);
    drain();
    steady = 1'b0;

    write_modulus(31'd1);
    queue_request(63'd5, '0);
    queue_request(63'd5, 63'd1);
    queue_request('0, '0);
    add_random_requests(20);
    drain();

    write_modulus('0);
    queue_request(63'd5, '0);
    queue_request(FIELD_MAX, FIELD_MAX);
    queue_request('0, 63'd1);
    add_random_requests(20);
    drain();

    write_modulus(31'd7);
    add_random_requests(30);
    drain();

    write_modulus(31'($urandom_range(32'h7FFF_FFFF, 2)));
    add_random_requests(40);
    drain();

    write_modulus(RESET_MODULUS);
    add_random_requests(15);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d results checked over %0d modulus settings, including 0, 1, 7 and 2^31-1.",
             results_checked, settings_used);
    $display("%0d random exponents spanned all 63 bits; one output stall of %0d cycles.",
             full_width_exps, STALL_CYCLES);
    if (mismatch_count == 0 && awaited_powers.size() == 0) begin
      $display("modular_exponentiation_top_test: done, clean");
    end else begin
      $display("modular_exponentiation_top_test: done, errors");
    end
    $finish;
  end

endmodule
